>>> hdl/assert_macros.svh
// Assertion macros shared by the box culling RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_NOW(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> hdl/bpsc_pkg.sv
// Types, widths and plane field helpers for the box plane set culler.
package bpsc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int MASK_W     = 6;
    localparam int LANES      = (NUM_PLANES < MASK_W) ? NUM_PLANES : MASK_W;
    localparam int AXES       = 3;
    localparam int COORD_W    = 16;
    localparam int C_W        = COORD_W + 1;
    localparam int MAG_W      = COORD_W + 1;
    localparam int PROD_W     = 34;
    localparam int SUM_W      = 36;
    localparam int DATA_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int IDX_W      = ADDR_W - 3;
    localparam int D_SHIFT    = 15;

    typedef logic [DATA_W-1:0] plane_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] min_x;
        logic signed [COORD_W-1:0] min_y;
        logic signed [COORD_W-1:0] min_z;
        logic signed [COORD_W-1:0] max_x;
        logic signed [COORD_W-1:0] max_y;
        logic signed [COORD_W-1:0] max_z;
        logic        [MASK_W-1:0]  active_mask;
    } box_t;

    typedef struct packed {
        logic              visible;
        logic [MASK_W-1:0] crossing_mask;
    } result_t;

    // Normal component for axis a (0 = x, 1 = y, 2 = z), signed Q1.14.
    function automatic logic signed [COORD_W-1:0] plane_nrm(input plane_t p, input int a);
        logic signed [COORD_W-1:0] n;
        begin
            case (a)
                0:       n = $signed(p[15:0]);
                1:       n = $signed(p[31:16]);
                default: n = $signed(p[47:32]);
            endcase
            return n;
        end
    endfunction

    // Plane offset, signed integer.
    function automatic logic signed [COORD_W-1:0] plane_dist(input plane_t p);
        return $signed(p[63:48]);
    endfunction

    // Magnitude of a signed component; the most negative code gives 2^15.
    function automatic logic [MAG_W-1:0] nrm_mag(input logic signed [COORD_W-1:0] n);
        logic signed [MAG_W-1:0] wide;
        begin
            wide = MAG_W'(n);
            return n[COORD_W-1] ? MAG_W'(-wide) : MAG_W'(wide);
        end
    endfunction

endpackage

>>> hdl/box_plane_set_cull.sv
// A box that is taken passes the four register stages (s1, s2, s3, res) before its result
// shows on res (res_valid high).
// Throughput: one box per cycle; all six plane tests run in parallel lanes and every stage
// takes a new item each cycle, so only back-pressure on res slows the pace.
// Back-pressure on res stalls only the stages that hold an item; bubbles close.
// Reset (rst_n low, asynchronous) empties all stages and clears the planes to 0.
`include "assert_macros.svh"

module box_plane_set_cull
    import bpsc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    // box channel
    input  logic              box_valid,
    output logic              box_ready,
    input  box_t              box,
    // result channel
    output logic              res_valid,
    input  logic              res_ready,
    output result_t           res,
    // plane register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    // ------------------------------------------------------------------
    // Plane registers: 64 bits each at byte address 8*i.
    // Writes to a slot past the last plane are dropped; reads there give 0.
    // ------------------------------------------------------------------
    plane_t             plane_reg [NUM_PLANES];
    logic [IDX_W-1:0]   cfg_idx;
    logic               cfg_wr;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                plane_reg[p] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            for (int p = 0; p < NUM_PLANES; p++)
            begin
                if (cfg_idx == IDX_W'(p))
                begin
                    plane_reg[p] <= pwdata;
                end
            end
        end
    end

    always_comb
    begin
        prdata = '0;
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            if (cfg_idx == IDX_W'(p))
            begin
                prdata = plane_reg[p];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage handshake: a stage takes a new item when it is empty or when
    // its own item moves on in the same cycle.
    // ------------------------------------------------------------------
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, res_valid_reg;
    logic s1_ready, s2_ready, s3_ready, s4_ready;

    assign s4_ready  = !res_valid_reg || res_ready;
    assign s3_ready  = !s3_valid_reg || s4_ready;
    assign s2_ready  = !s2_valid_reg || s3_ready;
    assign s1_ready  = !s1_valid_reg || s2_ready;
    assign box_ready = s1_ready;
    assign res_valid = res_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= box_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (s4_ready)
            begin
                res_valid_reg <= s3_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: doubled centre (min + max) and doubled extent (max - min).
    // Inverted corners give a negative extent, kept as is.
    // ------------------------------------------------------------------
    logic signed [COORD_W-1:0] box_lo [AXES];
    logic signed [COORD_W-1:0] box_hi [AXES];
    logic signed [C_W-1:0]     c2_next [AXES];
    logic signed [C_W-1:0]     e2_next [AXES];
    logic signed [C_W-1:0]     s1_c2_reg [AXES];
    logic signed [C_W-1:0]     s1_e2_reg [AXES];
    logic [MASK_W-1:0]         s1_mask_reg;

    assign box_lo[0] = box.min_x;
    assign box_lo[1] = box.min_y;
    assign box_lo[2] = box.min_z;
    assign box_hi[0] = box.max_x;
    assign box_hi[1] = box.max_y;
    assign box_hi[2] = box.max_z;

    always_comb
    begin
        for (int a = 0; a < AXES; a++)
        begin
            c2_next[a] = C_W'(box_lo[a]) + C_W'(box_hi[a]);
            e2_next[a] = C_W'(box_hi[a]) - C_W'(box_lo[a]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && box_valid)
        begin
            s1_c2_reg   <= c2_next;
            s1_e2_reg   <= e2_next;
            s1_mask_reg <= box.active_mask;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: per plane and axis, centre times normal and extent times
    // the normal's magnitude.
    // ------------------------------------------------------------------
    logic signed [PROD_W-1:0] cn_next [LANES][AXES];
    logic signed [PROD_W-1:0] en_next [LANES][AXES];
    logic signed [PROD_W-1:0] s2_cn_reg [LANES][AXES];
    logic signed [PROD_W-1:0] s2_en_reg [LANES][AXES];
    logic [MASK_W-1:0]        s2_mask_reg;

    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            for (int a = 0; a < AXES; a++)
            begin
                cn_next[p][a] = PROD_W'(s1_c2_reg[a]) * PROD_W'(plane_nrm(plane_reg[p], a));
                en_next[p][a] = PROD_W'(s1_e2_reg[a])
                              * PROD_W'($signed({1'b0, nrm_mag(plane_nrm(plane_reg[p], a))}));
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_cn_reg   <= cn_next;
            s2_en_reg   <= en_next;
            s2_mask_reg <= s1_mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: centre distance M (with d scaled by 2^15) and projected
    // half extent N, both at scale 2 * 2^14.
    // ------------------------------------------------------------------
    logic signed [SUM_W-1:0] m_next [LANES];
    logic signed [SUM_W-1:0] np_next [LANES];
    logic signed [SUM_W-1:0] s3_m_reg [LANES];
    logic signed [SUM_W-1:0] s3_np_reg [LANES];
    logic [MASK_W-1:0]       s3_mask_reg;

    always_comb
    begin
        for (int p = 0; p < LANES; p++)
        begin
            m_next[p]  = SUM_W'(s2_cn_reg[p][0]) + SUM_W'(s2_cn_reg[p][1])
                       + SUM_W'(s2_cn_reg[p][2])
                       + (SUM_W'(plane_dist(plane_reg[p])) <<< D_SHIFT);
            np_next[p] = SUM_W'(s2_en_reg[p][0]) + SUM_W'(s2_en_reg[p][1])
                       + SUM_W'(s2_en_reg[p][2]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && s2_valid_reg)
        begin
            s3_m_reg    <= m_next;
            s3_np_reg   <= np_next;
            s3_mask_reg <= s2_mask_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: behind when M + N < 0, straddling when M - N < 0. Any active
    // plane with the box behind it hides the box and clears the crossings.
    // ------------------------------------------------------------------
    logic [MASK_W-1:0]       behind_vec;
    logic [MASK_W-1:0]       cross_vec;
    logic signed [SUM_W-1:0] tot [LANES];
    logic signed [SUM_W-1:0] dif [LANES];
    result_t                 res_next;
    result_t                 res_reg;

    always_comb
    begin
        behind_vec = '0;
        cross_vec  = '0;
        for (int p = 0; p < LANES; p++)
        begin
            tot[p]        = s3_m_reg[p] + s3_np_reg[p];
            dif[p]        = s3_m_reg[p] - s3_np_reg[p];
            behind_vec[p] = s3_mask_reg[p] && tot[p][SUM_W-1];
            cross_vec[p]  = s3_mask_reg[p] && dif[p][SUM_W-1];
        end
        res_next.visible       = (behind_vec == '0);
        res_next.crossing_mask = res_next.visible ? cross_vec : '0;
    end

    always_ff @(posedge clk)
    begin
        if (s4_ready && s3_valid_reg)
        begin
            res_reg <= res_next;
        end
    end

    assign res = res_reg;

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `ASSERT_NEXT(a_accept_fills_s1, clk, rst_n, box_valid && box_ready, s1_valid_reg)
    `ASSERT_NEXT(a_s2_moves_on, clk, rst_n, s2_valid_reg && s3_ready, s3_valid_reg)
    `ASSERT_NOW(a_hidden_no_cross, clk, rst_n, res_valid_reg && !res_reg.visible, res_reg.crossing_mask == '0)
    `ASSERT_NEXT(a_cross_in_mask, clk, rst_n, s3_valid_reg && s4_ready, res_valid_reg && ((res_reg.crossing_mask & ~$past(s3_mask_reg)) == '0))

endmodule

>>> test/tb_box_plane_set_cull.sv
`timescale 1ns / 100ps
// Self-checking bench for the box plane set culler: random boxes against changing plane sets.

module tb_box_plane_set_cull;
    import bpsc_pkg::*;

    localparam int DRAIN_CYCLES = 8;       // a few more than the four-stage pipe
    localparam int CYCLE_LIMIT  = 400000;  // far above the slowest legal run
    localparam int PHASE_ITEMS  = 190;
    localparam int PHASES       = 5;
    localparam int REPORT_MAX   = 10;

    // Scoreboard: holds the plane copy, predicts each box and matches results in order.
    class cull_scoreboard;
        plane_t  planes[NUM_PLANES];
        result_t pending[$];
        int      failures;

        function new();
            for (int i = 0; i < NUM_PLANES; i++)
                planes[i] = '0;
            failures = 0;
        endfunction

        function void set_plane(int idx, plane_t value);
            if (idx < NUM_PLANES)
                planes[idx] = value;
        endfunction

        function result_t cull_predict(box_t b);
            logic signed [COORD_W-1:0] lo[3];
            logic signed [COORD_W-1:0] hi[3];
            longint                    c2[3];
            longint                    e2[3];
            longint                    n[3];
            longint                    d, m, np;
            result_t                   r;
            lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
            hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
            for (int a = 0; a < 3; a++)
            begin
                c2[a] = longint'(lo[a]) + longint'(hi[a]);
                e2[a] = longint'(hi[a]) - longint'(lo[a]);
            end
            r.visible       = 1'b1;
            r.crossing_mask = '0;
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                if (b.active_mask[i])
                begin
                    for (int a = 0; a < 3; a++)
                        n[a] = longint'($signed(planes[i][16*a +: 16]));
                    d  = longint'($signed(planes[i][63:48]));
                    m  = c2[0] * n[0] + c2[1] * n[1] + c2[2] * n[2] + d * 32768;
                    np = 0;
                    for (int a = 0; a < 3; a++)
                        np += e2[a] * ((n[a] < 0) ? -n[a] : n[a]);
                    if (m + np < 0)
                    begin
                        r.visible       = 1'b0;
                        r.crossing_mask = '0;
                        return r;
                    end
                    if (m - np < 0)
                        r.crossing_mask[i] = 1'b1;
                end
            end
            return r;
        endfunction

        function void note_box(box_t b);
            pending.push_back(cull_predict(b));
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (pending.size() == 0)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("unexpected result: visible=%0d crossing=%b",
                             got.visible, got.crossing_mask);
                return;
            end
            want = pending.pop_front();
            if (got.visible !== want.visible || got.crossing_mask !== want.crossing_mask)
            begin
                failures++;
                if (failures <= REPORT_MAX)
                    $display("mismatch: expected visible=%0d crossing=%b, got visible=%0d crossing=%b",
                             want.visible, want.crossing_mask, got.visible, got.crossing_mask);
            end
        endfunction

        function int outstanding();
            return pending.size();
        endfunction
    endclass

    // Clock, reset and every block input start at known values.
    logic              clk       = 1'b0;
    logic              rst_n     = 1'b0;
    logic              box_valid = 1'b0;
    logic              box_ready;
    box_t              box       = '0;
    logic              res_valid;
    logic              res_ready = 1'b0;
    result_t           res;
    logic              psel      = 1'b0;
    logic              penable   = 1'b0;
    logic              pwrite    = 1'b0;
    logic [ADDR_W-1:0] paddr     = '0;
    logic [DATA_W-1:0] pwdata    = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    cull_scoreboard sb = new();
    plane_t         plane_set[NUM_PLANES];
    int             stall_mode = 0;   // receiver pattern for the current phase
    int             max_gap    = 0;   // longest sender gap; 0 means no idling
    int             stall_ctr  = 0;
    int             stall_left = 0;
    int             cycle_count = 0;

    box_plane_set_cull dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .box_valid (box_valid),
        .box_ready (box_ready),
        .box       (box),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    always #5 clk = ~clk;

    // Guard against a hung pipe: give up well past any legal run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Result side: check on the handshake, then choose next cycle's ready.
    // Mode 0 never stalls, mode 1 stalls at random, mode 2 follows a fixed
    // duty cycle, mode 3 throws in occasional long stalls.
    always @(posedge clk)
    begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res);
        stall_ctr <= stall_ctr + 1;
        case (stall_mode)
            1:
                res_ready <= ($urandom_range(0, 9) > 2);
            2:
                res_ready <= ((stall_ctr % 7) < 4);
            3:
            begin
                if (stall_left > 0)
                begin
                    res_ready  <= 1'b0;
                    stall_left <= stall_left - 1;
                end
                else
                begin
                    res_ready <= 1'b1;
                    if ($urandom_range(0, 7) == 0)
                        stall_left <= $urandom_range(1, 12);
                end
            end
            default:
                res_ready <= 1'b1;
        endcase
    end

    // Write one plane register: setup phase, access phase until pready, then back to idle.
    task automatic write_plane(int idx, plane_t value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(idx * 8);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sb.set_plane(idx, value);
        @(posedge clk);
    endtask

    task automatic apply_planes();
        for (int i = 0; i < NUM_PLANES; i++)
            write_plane(i, plane_set[i]);
    endtask

    // Present one box and hold it until the block takes it. Valid is left high
    // so that a following item in the same burst goes out back to back.
    task automatic send_box(box_t b);
        box       <= b;
        box_valid <= 1'b1;
        do
            @(posedge clk);
        while (!box_ready);
        sb.note_box(b);
    endtask

    // Drop valid, let every outstanding result come back, then let the pipe settle.
    task automatic drain();
        box_valid <= 1'b0;
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic box_t mk_box(int x0, int y0, int z0, int x1, int y1, int z1,
                                    logic [MASK_W-1:0] mask);
        box_t b;
        b.min_x       = COORD_W'(x0);
        b.min_y       = COORD_W'(y0);
        b.min_z       = COORD_W'(z0);
        b.max_x       = COORD_W'(x1);
        b.max_y       = COORD_W'(y1);
        b.max_z       = COORD_W'(z1);
        b.active_mask = mask;
        return b;
    endfunction

    function automatic int clamp16(int v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // Mostly well-formed boxes of mixed sizes; some inverted, some raw bit patterns.
    function automatic box_t random_box();
        int                lo[3], hi[3];
        int                centre, half, tmp;
        int                kind;
        logic [MASK_W-1:0] mask;
        kind = $urandom_range(0, 9);
        mask = ($urandom_range(0, 9) < 3) ? '1 : MASK_W'($urandom_range(0, 63));
        if (kind == 0)
            return mk_box($urandom, $urandom, $urandom, $urandom, $urandom, $urandom, mask);
        for (int a = 0; a < 3; a++)
        begin
            centre = int'($urandom_range(0, 65535)) - 32768;
            case ($urandom_range(0, 3))
                0:       half = $urandom_range(0, 15);
                1:       half = $urandom_range(0, 1023);
                2:       half = $urandom_range(0, 16383);
                default: half = $urandom_range(0, 65535);
            endcase
            lo[a] = clamp16(centre - half);
            hi[a] = clamp16(centre + half);
            // now and then invert a random subset of the axes
            if (kind == 1 && $urandom_range(0, 1) == 1)
            begin
                tmp   = lo[a];
                lo[a] = hi[a];
                hi[a] = tmp;
            end
        end
        return mk_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], mask);
    endfunction

    // Plane with a normal of up to unit length per axis and a random offset.
    function automatic plane_t frustum_plane();
        logic [15:0] comp[3];
        int          mag;
        for (int a = 0; a < 3; a++)
        begin
            mag     = $urandom_range(0, 16384);
            comp[a] = ($urandom_range(0, 1) == 1) ? 16'(-mag) : 16'(mag);
        end
        return {16'($urandom), comp[2], comp[1], comp[0]};
    endfunction

    // Send a stretch of random boxes in bursts, with gaps when max_gap allows.
    task automatic run_items(int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 40);
            for (int j = 0; j < burst && sent < count; j++)
            begin
                send_box(random_box());
                sent++;
            end
            gap = (max_gap > 0) ? $urandom_range(0, max_gap) : 0;
            // only lower valid when a real gap follows
            if (gap > 0)
            begin
                box_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    initial
    begin
        // Hold reset low, then release it on a clock edge.
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Planes are still zero after reset: nothing is behind, nothing crosses.
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 6'h3F));
        send_box(mk_box(100, 100, 100, -100, -100, -100, 6'h00));
        drain();

        // Directed planes: x >= 0, x <= 500 with a -2.0 normal, a tilted plane,
        // all-ones fields, the largest positive fields, and one left at zero.
        plane_set[0] = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
        plane_set[1] = {16'sd1000, 16'sd0, 16'sd0, 16'h8000};
        plane_set[2] = {-16'sd50, -16'sd16384, 16'sd16384, 16'sd0};
        plane_set[3] = 64'hFFFF_FFFF_FFFF_FFFF;
        plane_set[4] = 64'h7FFF_7FFF_7FFF_7FFF;
        plane_set[5] = 64'h0;
        apply_planes();

        send_box(mk_box(10, 0, 0, 20, 0, 0, 6'h01));        // fully inside
        send_box(mk_box(-20, 0, 0, -10, 0, 0, 6'h01));      // fully behind
        send_box(mk_box(-5, 0, 0, 5, 0, 0, 6'h01));         // straddles
        send_box(mk_box(600, 0, 0, 700, 0, 0, 6'h02));      // behind the -2.0 plane
        send_box(mk_box(400, 0, 0, 600, 0, 0, 6'h03));      // straddles the -2.0 plane
        send_box(mk_box(20, 0, 0, -20, 0, 0, 6'h01));       // inverted, negative extent
        send_box(mk_box(30, 0, 0, 10, 0, 0, 6'h01));        // inverted, still in front
        send_box(mk_box(-60, -60, -60, 60, 60, 60, 6'h04));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 6'h3F));
        send_box(mk_box(32767, 32767, 32767, 32767, 32767, 32767, 6'h3F));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, 6'h3F));
        send_box(mk_box(-32768, -32768, -32768, -32768, -32768, -32768, 6'h00));
        send_box(mk_box(32767, -32768, 32767, -32768, 32767, -32768, 6'h20));
        send_box(mk_box(-32768, -32768, -32768, 32767, 32767, 32767, 6'h10));
        send_box(mk_box(32767, 32767, 32767, -32768, -32768, -32768, 6'h08));
        send_box(mk_box(-1, -1, -1, 1, 1, 1, 6'h18));
        drain();

        // Random phases, each with a new plane set, a receiver pattern and a gap limit.
        for (int p = 0; p < PHASES; p++)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                case (p)
                    0, 4:
                        plane_set[i] = {$urandom, $urandom};
                    1:
                        plane_set[i] = frustum_plane();
                    2:
                    begin
                        case (i)
                            0:       plane_set[i] = 64'h7FFF_7FFF_7FFF_7FFF;
                            1:       plane_set[i] = 64'h8000_8000_8000_8000;
                            2:       plane_set[i] = 64'hFFFF_FFFF_FFFF_FFFF;
                            3:       plane_set[i] = 64'h0;
                            4:       plane_set[i] = 64'h8000_7FFF_8000_7FFF;
                            default: plane_set[i] = 64'h7FFF_8000_7FFF_8000;
                        endcase
                    end
                    default:
                        plane_set[i] = (i % 2 == 0) ? 64'h0 : frustum_plane();
                endcase
            end
            apply_planes();
            // Slots past the last plane exist in the address map but hold nothing.
            if (p == 3)
            begin
                write_plane(NUM_PLANES, {$urandom, $urandom});
                write_plane(NUM_PLANES + 1, 64'hFFFF_FFFF_FFFF_FFFF);
            end
            stall_mode = p % 4;
            max_gap    = (p == 0) ? 0 : 3 * p;
            run_items(PHASE_ITEMS);
            drain();
        end

        if (sb.outstanding() != 0)
        begin
            sb.failures++;
            $display("%0d expected results never arrived", sb.outstanding());
        end
        if (sb.failures == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hdl
hdl/bpsc_pkg.sv
hdl/box_plane_set_cull.sv
test/tb_box_plane_set_cull.sv
